FILE: hdl/l2h_pkg.sv
// Shared types and constants for the log2 size histogram.
package l2h_pkg;

    localparam int VAL_W  = 32;
    localparam int CNT_W  = 48;
    localparam int SUM_W  = 64;
    localparam int IDX_W  = 5;
    localparam int BIN_W  = 6;
    localparam int CMP_W  = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 296;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic {
        ACT_RECORD = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] least;
        logic [VAL_W-1:0] greatest;
    } t_bin_stat;

    localparam t_bin_stat STAT_RESET = '{
        count:    '0,
        sum:      '0,
        least:    '1,
        greatest: '0
    };

    typedef struct packed {
        t_action          act;
        logic [VAL_W-1:0] sample;
        logic [BIN_W-1:0] idx;
        logic             oor;
        logic             bin_ok;
    } t_s1_item;

    typedef struct packed {
        logic [SUM_W-1:0] total_sum;
        logic [CNT_W-1:0] total_count;
        logic [VAL_W-1:0] greatest;
        logic [VAL_W-1:0] least;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] bin_index;
    } t_result;

endpackage

FILE: hdl/log2_size_histogram.sv
// Top level of the power-of-two size histogram with per-bin statistics.
//
//  channel  dir  tdata                                   tuser
//  s        in   sample_size, read_bin                   action
//  m        out  bin_index, bin/total count, sum, min/max out_of_range
//
// One beat per cycle sustained while the output is not stalled. The bin
// memory read and the stage-1 register are loaded at the accepting edge; the
// update is combinational into the output register, loaded when stage 1 fires.
// A write to the bin being read in the same cycle is forwarded. Reset clears
// the per-bin valid bits at once; no clearing pass.
// A stalled output holds the update stage, which in turn holds tready low.
module log2_size_histogram
    import l2h_pkg::*;
#(
    parameter int NUM_BINS    = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // sample_size[31:0], read_bin[36:32], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // action[0]
    input  logic [0:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // bin_index[4:0], bin_count[52:5], bin_sum[116:53], bin_least[148:117],
    // bin_greatest[180:149], total_count[228:181], total_sum[292:229], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // out_of_range[0]
    output logic [0:0]             o_m_tuser
);

    localparam int ADDR_W = $clog2(NUM_BINS);

    logic [VAL_W-1:0]  s_sample;
    logic [IDX_W-1:0]  s_read_bin;
    t_action           s_act;
    logic [VAL_W-1:0]  enc_sample;
    logic [BIN_W-1:0]  enc_bin;
    logic              enc_oor;

    t_s1_item          n_s1_item;
    t_s1_item          r_s1_item;
    logic              r_s1_vld;
    logic              r_s1_fwd;
    t_bin_stat         r_fwd_data;

    logic              accept;
    logic              fire;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic              upd_wr_en;
    t_bin_stat         wr_data;
    t_bin_stat         mem_data;
    t_bin_stat         cur_stat;

    logic [CNT_W-1:0]  r_tot_count;
    logic [SUM_W-1:0]  r_tot_sum;
    logic [CNT_W-1:0]  n_tot_count;
    logic [SUM_W-1:0]  n_tot_sum;
    t_result           n_result;
    t_result           r_result;
    logic              r_res_oor;
    logic              r_out_vld;

    assign s_sample   = i_s_tdata[VAL_W-1:0];
    assign s_read_bin = i_s_tdata[VAL_W +: IDX_W];
    assign s_act      = t_action'(i_s_tuser[0]);

    l2h_bin_enc #(
        .NUM_BINS    (NUM_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_enc (
        .i_sample (s_sample),
        .o_sample (enc_sample),
        .o_bin    (enc_bin),
        .o_oor    (enc_oor)
    );

    always_comb begin
        n_s1_item.act    = s_act;
        n_s1_item.sample = enc_sample;
        unique case (s_act)
            ACT_RECORD: begin
                n_s1_item.idx    = enc_bin;
                n_s1_item.oor    = enc_oor;
                n_s1_item.bin_ok = !enc_oor;
            end
            ACT_READ: begin
                n_s1_item.idx    = BIN_W'(s_read_bin);
                n_s1_item.oor    = 1'b0;
                n_s1_item.bin_ok = CMP_W'(s_read_bin) < CMP_W'(NUM_BINS);
            end
            default: begin
                n_s1_item.idx    = '0;
                n_s1_item.oor    = 1'b0;
                n_s1_item.bin_ok = 1'b0;
            end
        endcase
    end

    assign fire       = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || fire;
    assign accept     = i_s_tvalid && o_s_tready;
    assign rd_addr    = ADDR_W'(n_s1_item.idx);
    assign wr_addr    = ADDR_W'(r_s1_item.idx);
    assign wr_en      = fire && upd_wr_en;

    l2h_stat_mem #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && n_s1_item.bin_ok),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (mem_data)
    );

    assign cur_stat = r_s1_fwd ? r_fwd_data : mem_data;

    l2h_update u_upd (
        .i_item      (r_s1_item),
        .i_stat      (cur_stat),
        .i_tot_count (r_tot_count),
        .i_tot_sum   (r_tot_sum),
        .o_wr_en     (upd_wr_en),
        .o_wr_data   (wr_data),
        .o_tot_count (n_tot_count),
        .o_tot_sum   (n_tot_sum),
        .o_result    (n_result)
    );

    // stage 1 and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_fwd <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
                r_s1_fwd <= wr_en && (wr_addr == rd_addr);
            end else if (fire) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= n_s1_item;
            r_fwd_data <= wr_data;
        end
    end

    // totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_count <= '0;
            r_tot_sum   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (fire) begin
                r_tot_count <= n_tot_count;
                r_tot_sum   <= n_tot_sum;
                r_out_vld   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result  <= n_result;
            r_res_oor <= r_s1_item.oor;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TDATA_W'(r_result);
    assign o_m_tuser  = r_res_oor;

endmodule

FILE: hdl/l2h_bin_enc.sv
// Sample masking and power-of-two bin encoder.
module l2h_bin_enc
    import l2h_pkg::*;
#(
    parameter int NUM_BINS    = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic [VAL_W-1:0] i_sample,
    output logic [VAL_W-1:0] o_sample,
    output logic [BIN_W-1:0] o_bin,
    output logic             o_oor
);

    localparam logic [VAL_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= VAL_W) ? '1 :
        VAL_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] d;
    logic [BIN_W-1:0] len;

    always_comb begin
        s   = i_sample & SAMPLE_MASK;
        d   = s - VAL_W'(1);
        len = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (d[i]) begin
                len = BIN_W'(i + 1);
            end
        end
        o_sample = s;
        o_bin    = (s == '0) ? '0 : len + BIN_W'(1);
        o_oor    = CMP_W'(o_bin) >= CMP_W'(NUM_BINS);
    end

endmodule

FILE: hdl/l2h_stat_mem.sv
// Per-bin statistics memory, registered read, per-entry valid bits.
module l2h_stat_mem
    import l2h_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_bin_stat         i_wr_data,
    output t_bin_stat         o_rd_data
);

    t_bin_stat        r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_bin_stat        r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : STAT_RESET;

endmodule

FILE: hdl/l2h_update.sv
// Read-modify-write datapath: bin update, totals and result assembly.
module l2h_update
    import l2h_pkg::*;
(
    input  t_s1_item          i_item,
    input  t_bin_stat         i_stat,
    input  logic [CNT_W-1:0]  i_tot_count,
    input  logic [SUM_W-1:0]  i_tot_sum,
    output logic              o_wr_en,
    output t_bin_stat         o_wr_data,
    output logic [CNT_W-1:0]  o_tot_count,
    output logic [SUM_W-1:0]  o_tot_sum,
    output t_result           o_result
);

    logic             rec;
    logic [SUM_W:0]   bin_add;
    logic [SUM_W:0]   tot_add;
    t_bin_stat        shown;

    always_comb begin
        rec     = (i_item.act == ACT_RECORD) && !i_item.oor;
        bin_add = {1'b0, i_stat.sum} + (SUM_W+1)'(i_item.sample);
        tot_add = {1'b0, i_tot_sum} + (SUM_W+1)'(i_item.sample);

        o_wr_data.count    = (i_stat.count == CNT_MAX) ? CNT_MAX
                                                       : i_stat.count + CNT_W'(1);
        o_wr_data.sum      = bin_add[SUM_W] ? SUM_MAX : bin_add[SUM_W-1:0];
        o_wr_data.least    = (i_item.sample < i_stat.least) ? i_item.sample
                                                            : i_stat.least;
        o_wr_data.greatest = (i_item.sample > i_stat.greatest) ? i_item.sample
                                                               : i_stat.greatest;
        o_wr_en = rec;

        if (rec) begin
            o_tot_count = (i_tot_count == CNT_MAX) ? CNT_MAX
                                                   : i_tot_count + CNT_W'(1);
            o_tot_sum   = tot_add[SUM_W] ? SUM_MAX : tot_add[SUM_W-1:0];
        end else begin
            o_tot_count = i_tot_count;
            o_tot_sum   = i_tot_sum;
        end

        shown = rec ? o_wr_data : i_stat;

        o_result.total_sum   = o_tot_sum;
        o_result.total_count = o_tot_count;
        if (i_item.bin_ok) begin
            o_result.count    = shown.count;
            o_result.sum      = shown.sum;
            o_result.least    = (shown.count != '0) ? shown.least : '0;
            o_result.greatest = shown.greatest;
        end else begin
            o_result.count    = '0;
            o_result.sum      = '0;
            o_result.least    = '0;
            o_result.greatest = '0;
        end
        o_result.bin_index = i_item.oor ? '0 : i_item.idx[IDX_W-1:0];
    end

endmodule

FILE: hdl/l2h_checker.sv
// Port-level checks for the log2 size histogram, bound to the top level.
module l2h_checker
    import l2h_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]             o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[180:0] == '0)
        else $error("dropped sample shows bin fields");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[52:5] != '0 |->
            o_m_tdata[148:117] <= o_m_tdata[180:149])
        else $error("bin minimum above bin maximum");

    a_bin_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            o_m_tdata[52:5] <= o_m_tdata[228:181] &&
            o_m_tdata[116:53] <= o_m_tdata[292:229])
        else $error("bin statistics exceed totals");

endmodule

bind log2_size_histogram l2h_checker u_l2h_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the log2 size histogram: stream stimulus and a bin-statistics model.
module tb_top
    import l2h_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BINS    = 32;
    localparam int SAMPLE_BITS = 32;
    localparam int MAX_GAP     = 18;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic             oor;
        logic [CNT_W-1:0] bin_count;
        logic [SUM_W-1:0] bin_sum;
        logic [VAL_W-1:0] bin_least;
        logic [VAL_W-1:0] bin_greatest;
        logic [CNT_W-1:0] total_count;
        logic [SUM_W-1:0] total_sum;
    } t_hist_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // sample_size[31:0], read_bin[36:32], zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    // action[0]
    logic [0:0]             i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // bin_index[4:0], bin_count[52:5], bin_sum[116:53], bin_least[148:117],
    // bin_greatest[180:149], total_count[228:181], total_sum[292:229], zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // out_of_range[0]
    logic [0:0]             o_m_tuser;

    log2_size_histogram #(
        .NUM_BINS    (NUM_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    logic [CNT_W-1:0] cnt_bin      [NUM_BINS];
    logic [SUM_W-1:0] sum_bin      [NUM_BINS];
    logic [VAL_W-1:0] least_bin    [NUM_BINS];
    logic [VAL_W-1:0] greatest_bin [NUM_BINS];
    logic [CNT_W-1:0] model_tot_count;
    logic [SUM_W-1:0] total_bytes;

    t_hist_result pending_results[$];
    bit  idling = 1'b1;
    int  err_count;
    int  cycle_count;
    int  n_records;
    int  n_dropped;
    int  n_reads;
    int  n_checked;

    function automatic int size_to_bin(logic [VAL_W-1:0] s);
        int i;
        if (s == '0)
            return 0;
        for (i = 1; i < NUM_BINS; i++)
            if ({32'd0, s} <= (64'd1 << (i - 1)))
                return i;
        return NUM_BINS;
    endfunction

    function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] a, logic [VAL_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(v);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_sat(logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic t_hist_result histogram_predict(t_action act, logic [VAL_W-1:0] size,
                                                       logic [IDX_W-1:0] rbin);
        t_hist_result r;
        int b;
        r = '0;
        b = -1;
        if (act == ACT_READ) begin
            b = int'(rbin);
            r.bin_index = rbin;
            n_reads++;
        end else begin
            b = size_to_bin(size);
            if (b >= NUM_BINS) begin
                r.oor = 1'b1;
                b = -1;
                n_dropped++;
            end else begin
                cnt_bin[b] = cnt_sat(cnt_bin[b]);
                sum_bin[b] = sum_sat(sum_bin[b], size);
                if (size < least_bin[b])
                    least_bin[b] = size;
                if (size > greatest_bin[b])
                    greatest_bin[b] = size;
                model_tot_count = cnt_sat(model_tot_count);
                total_bytes     = sum_sat(total_bytes, size);
                r.bin_index = b[IDX_W-1:0];
                n_records++;
            end
        end
        if (b >= 0 && b < NUM_BINS) begin
            r.bin_count    = cnt_bin[b];
            r.bin_sum      = sum_bin[b];
            r.bin_least    = (cnt_bin[b] != '0) ? least_bin[b] : '0;
            r.bin_greatest = greatest_bin[b];
        end
        r.total_count = model_tot_count;
        r.total_sum   = total_bytes;
        return r;
    endfunction

    // random size that lands in bin b, edges favored
    function automatic logic [VAL_W-1:0] size_in_bin(int b);
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        if (b <= 1)
            return VAL_W'(b);
        lo = (32'd1 << (b - 2)) + 32'd1;
        hi = 32'd1 << (b - 1);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic send_beat(input t_action act, input logic [VAL_W-1:0] size,
                             input logic [IDX_W-1:0] rbin);
        int gap;
        gap = (idling && $urandom_range(0, 1)) ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, rbin, size};
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1)
            @(posedge i_clk);
        pending_results.push_back(histogram_predict(act, size, rbin));
    endtask

    task automatic record_size(input logic [VAL_W-1:0] size);
        send_beat(ACT_RECORD, size, IDX_W'($urandom));
    endtask

    task automatic read_back(input logic [IDX_W-1:0] rbin);
        send_beat(ACT_READ, $urandom, rbin);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            record_size(size_in_bin($urandom_range(0, NUM_BINS - 1)));
        else if (pick < 68)
            record_size($urandom_range(32'hFFFF_FFFF, 32'h4000_0001));
        else if (pick < 72)
            record_size($urandom);
        else
            read_back(IDX_W'($urandom_range(0, NUM_BINS - 1)));
    endtask

    // empty bins, bin boundaries, oversize drops
    task automatic test_directed();
        idling = 1'b1;
        read_back(5'd0);
        read_back(5'd31);
        record_size(32'd0);
        record_size(32'd1);
        record_size(32'd2);
        record_size(32'd3);
        record_size(32'd4);
        record_size(32'h4000_0000);
        record_size(32'h2000_0001);
        record_size(32'h4000_0001);
        record_size(32'hFFFF_FFFF);
        record_size(32'h8000_0000);
        record_size(32'h1000_0000);
        record_size(32'd0);
        read_back(5'd0);
        read_back(5'd1);
        read_back(5'd2);
        read_back(5'd3);
        read_back(5'd31);
        read_back(5'd29);
        read_back(5'd30);
        read_back(5'd21);
        read_back(5'd10);
    endtask

    task automatic test_random_traffic(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if (k % 50 == 0)
                idling = $urandom_range(0, 3) != 0;
            random_item();
        end
        idling = 1'b1;
    endtask

    // back-to-back updates and reads on one hot bin, with some records to its neighbour, to hit the forwarding path
    task automatic test_hot_bin(input int n);
        int k;
        int hot;
        idling = 1'b0;
        hot = $urandom_range(0, NUM_BINS - 1);
        for (k = 0; k < n; k++) begin
            if (k % 40 == 0)
                hot = $urandom_range(0, NUM_BINS - 1);
            case ($urandom_range(0, 3))
                0: read_back(IDX_W'(hot));
                1: record_size(size_in_bin(($urandom_range(0, 1) != 0) ? hot : hot ^ 1));
                default: record_size(size_in_bin(hot));
            endcase
        end
        idling = 1'b1;
    endtask

    task automatic test_drain_pause(input int rounds, input int per_round);
        int r;
        int k;
        idling = 1'b1;
        for (r = 0; r < rounds; r++) begin
            for (k = 0; k < per_round; k++)
                random_item();
            i_s_tvalid <= 1'b0;
            wait_drained();
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hist_result want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation pending");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("bin_index",    64'(want.bin_index),    64'(o_m_tdata[4:0]));
                check_field("out_of_range", 64'(want.oor),          64'(o_m_tuser[0]));
                check_field("bin_count",    64'(want.bin_count),    64'(o_m_tdata[52:5]));
                check_field("bin_sum",      want.bin_sum,           o_m_tdata[116:53]);
                check_field("bin_least",    64'(want.bin_least),    64'(o_m_tdata[148:117]));
                check_field("bin_greatest", 64'(want.bin_greatest), 64'(o_m_tdata[180:149]));
                check_field("total_count",  64'(want.total_count),  64'(o_m_tdata[228:181]));
                check_field("total_sum",    want.total_sum,         o_m_tdata[292:229]);
            end
        end
    end

    // output backpressure
    initial begin
        int stall;
        forever begin
            stall = (idling && $urandom_range(0, 1)) ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(i_rst_n && o_m_tvalid === 1'b1))
                @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_BINS; i++) begin
            cnt_bin[i]      = '0;
            sum_bin[i]      = '0;
            least_bin[i]    = '1;
            greatest_bin[i] = '0;
        end
        model_tot_count = '0;
        total_bytes     = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(560);
        test_hot_bin(200);
        test_drain_pause(5, 24);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d recorded samples, %0d oversize drops and %0d bin reads,",
                 n_records, n_dropped, n_reads);
        $display("with random gaps and stalls on both streams; %0d result beats compared.",
                 n_checked);
        if (err_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
